// ===== rtl/stl_pkg.sv =====
// shared constants, types and character helpers of the string to long parser
package stl_pkg;

  localparam int MAX_LENGTH  = 4096;
  localparam int VALUE_WIDTH = 64;
  localparam int OUT_W       = 64;
  localparam int POS_W       = $clog2(MAX_LENGTH);
  localparam int IDX_W       = 12;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 6;
  localparam int TDATA_W     = ((OUT_W + IDX_W + 7) / 8) * 8;
  localparam int TUSER_W     = 2;
  localparam int PROD_W      = VALUE_WIDTH + BASE_W;

  localparam logic [BASE_W-1:0] BASE_BIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);
  localparam logic [BASE_W-1:0] BASE_AUTO  = BASE_W'(0);
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_B = 8'h42;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_B = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] UPPER_OFS  = CH_UPPER_A - 8'd10;
  localparam logic [CHAR_W-1:0] LOWER_OFS  = CH_LOWER_A - 8'd10;

  typedef enum logic [5:0] {
    PH_SPACE  = 6'b000001,
    PH_FIRST  = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_PREFIX = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    SEL_RAW,
    SEL_FIRST,
    SEL_ZERO,
    SEL_ACTIVE,
    SEL_HEX,
    SEL_BIN
  } base_sel_t;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_ZERO,
    FIN_DIGITS,
    FIN_DONE
  } fin_sel_t;

  typedef struct packed {
    logic      item;
    logic      emit;
    logic      set_neg;
    logic      load_base;
    logic      take;
    logic      lead_zero;
    base_sel_t base_sel;
    fin_sel_t  fin_sel;
  } stl_cmd_t;

  typedef struct packed {
    logic ch_space;
    logic ch_minus;
    logic ch_plus;
    logic ch_zero;
    logic ch_x;
    logic ch_b;
    logic raw_zero;
    logic raw_hex;
    logic raw_bin;
    logic act_zero;
    logic act_hex;
    logic act_bin;
    logic digit_ok;
  } stl_stat_t;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - UPPER_OFS;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - LOWER_OFS;
    end else begin
      d = '0;
    end
    return d[DIGIT_W-1:0];
  endfunction

endpackage

// ===== rtl/string_to_long_parser.sv =====
// top level of the string to long parser: stream ports, controller and datapath
// The parser takes one character item per clock cycle, terminator included, as long
// as the result register is empty or being drained in that cycle; non-terminator
// items stall only while a finished result waits to be taken. The result appears on
// the master side in the cycle after the terminator is accepted. Each character goes
// through one multiply-add of the 64-bit accumulator by the 6-bit base together with
// the overflow compare in one combinational path, and that path sets the clock. The base
// register is written on the cfg channel, which is always ready; a new base applies
// to every string whose base is not yet chosen. There is no clearing pass after reset.
module string_to_long_parser import stl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] character
  input  logic               s_tlast,   // end_of_string
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [63:0] value, [75:64] end_index, rest zero
  output logic [TUSER_W-1:0] m_tuser,   // [0] overflowed, [1] had_digits
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BASE_W-1:0]  cfg_data   // number_base
);

  stl_cmd_t         cmd;
  stl_stat_t        stat;
  logic [OUT_W-1:0] value;
  logic [IDX_W-1:0] end_index;
  logic             overflowed;
  logic             had_digits;

  assign cfg_ready = 1'b1;

  stl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .m_tready (m_tready),
    .stat     (stat),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  stl_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .character  (s_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .value      (value),
    .end_index  (end_index),
    .overflowed (overflowed),
    .had_digits (had_digits)
  );

  assign m_tdata = TDATA_W'({end_index, value});
  assign m_tuser = {had_digits, overflowed};

endmodule

// ===== rtl/stl_datapath.sv =====
// parser datapath: base and string registers, digit multiply-add, result register
module stl_datapath import stl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [BASE_W-1:0]   cfg_data,
  input  logic [CHAR_W-1:0]   character,
  input  stl_cmd_t            cmd,
  output stl_stat_t           stat,
  output logic [OUT_W-1:0]    value,
  output logic [IDX_W-1:0]    end_index,
  output logic                overflowed,
  output logic                had_digits
);

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH - 1);
  localparam logic [VALUE_WIDTH-1:0] MIN_MAG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [BASE_W-1:0]      number_base;
  logic [BASE_W-1:0]      active_base;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] acc;
  logic                   overflow_seen;
  logic                   digit_seen;
  logic [POS_W-1:0]       position;
  logic [POS_W-1:0]       end_position;

  logic [BASE_W-1:0]      wbase;
  logic [DIGIT_W-1:0]     dval;
  logic                   digit_ok;
  logic [VALUE_WIDTH-1:0] lim;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      sum;
  logic                   ovf_now;
  logic                   seen_before;
  logic                   fin_had;
  logic [POS_W-1:0]       fin_end;
  logic [VALUE_WIDTH-1:0] res;

  always_comb begin
    case (cmd.base_sel)
      SEL_RAW:    wbase = number_base;
      SEL_FIRST:  wbase = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
      SEL_ZERO:   wbase = (active_base == BASE_AUTO) ? BASE_OCT : active_base;
      SEL_ACTIVE: wbase = active_base;
      SEL_HEX:    wbase = BASE_HEX;
      SEL_BIN:    wbase = BASE_BIN;
      default:    wbase = active_base;
    endcase
  end

  assign dval     = digit_value(character);
  assign digit_ok = is_alnum(character) && (BASE_W'(dval) < wbase);

  // largest magnitude the sign allows
  assign lim  = MIN_MAG - VALUE_WIDTH'(!negative);
  assign prod = PROD_W'(acc) * PROD_W'(wbase);
  assign sum  = prod + PROD_W'(dval);
  assign ovf_now = overflow_seen || (sum > PROD_W'(lim));
  // the implied leading zero counts as a digit already taken
  assign seen_before = digit_seen || cmd.lead_zero;

  always_comb begin
    stat.ch_space = (character == CH_SPACE) || (character >= CH_TAB && character <= CH_CR);
    stat.ch_minus = (character == CH_MINUS);
    stat.ch_plus  = (character == CH_PLUS);
    stat.ch_zero  = (character == CH_ZERO);
    stat.ch_x     = (character == CH_LOWER_X) || (character == CH_UPPER_X);
    stat.ch_b     = (character == CH_LOWER_B) || (character == CH_UPPER_B);
    stat.raw_zero = (number_base == BASE_AUTO);
    stat.raw_hex  = (number_base == BASE_HEX);
    stat.raw_bin  = (number_base == BASE_BIN);
    stat.act_zero = (active_base == BASE_AUTO);
    stat.act_hex  = (active_base == BASE_HEX);
    stat.act_bin  = (active_base == BASE_BIN);
    stat.digit_ok = digit_ok;
  end

  always_comb begin
    case (cmd.fin_sel)
      FIN_ZERO: begin
        fin_had = 1'b1;
        fin_end = position;
      end
      FIN_DIGITS: begin
        fin_had = digit_seen;
        fin_end = digit_seen ? position : '0;
      end
      FIN_DONE: begin
        fin_had = digit_seen;
        fin_end = end_position;
      end
      default: begin
        fin_had = 1'b0;
        fin_end = '0;
      end
    endcase
    if (overflow_seen) begin
      res = negative ? MIN_MAG : MIN_MAG - VALUE_WIDTH'(1);
    end else begin
      res = negative ? (VALUE_WIDTH'(0) - acc) : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base   <= BASE_RESET;
      active_base   <= BASE_AUTO;
      negative      <= 1'b0;
      acc           <= '0;
      overflow_seen <= 1'b0;
      digit_seen    <= 1'b0;
      position      <= '0;
      end_position  <= '0;
    end else begin
      if (cfg_write) begin
        number_base <= cfg_data;
      end
      if (cmd.emit) begin
        active_base   <= BASE_AUTO;
        negative      <= 1'b0;
        acc           <= '0;
        overflow_seen <= 1'b0;
        digit_seen    <= 1'b0;
        position      <= '0;
        end_position  <= '0;
      end else if (cmd.item) begin
        if (position < POS_MAX) begin
          position <= position + POS_W'(1);
        end
        if (cmd.set_neg) begin
          negative <= 1'b1;
        end
        if (cmd.load_base) begin
          active_base <= wbase;
        end
        if (cmd.take) begin
          if (digit_ok) begin
            if (!ovf_now) begin
              acc <= sum[VALUE_WIDTH-1:0];
            end
            overflow_seen <= ovf_now;
            digit_seen    <= 1'b1;
          end else begin
            digit_seen   <= seen_before;
            end_position <= seen_before ? position : '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      value      <= OUT_W'($signed(res));
      end_index  <= IDX_W'(fin_end);
      overflowed <= overflow_seen;
      had_digits <= fin_had;
    end
  end

  a_ovf_needs_digit: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> digit_seen)
    else $error("overflow flagged without any digit");

  a_acc_in_range: assert property (@(posedge clk) disable iff (rst)
    acc <= lim)
    else $error("accumulator beyond signed range");

  a_acc_needs_digit: assert property (@(posedge clk) disable iff (rst)
    !digit_seen |-> acc == '0)
    else $error("accumulator loaded without any digit");

endmodule

// ===== rtl/stl_ctrl.sv =====
// parser controller: phase state machine and stream handshakes
module stl_ctrl import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  input  logic      s_tlast,
  input  logic      m_tready,
  input  stl_stat_t stat,
  output logic      s_tready,
  output logic      m_tvalid,
  output stl_cmd_t  cmd
);

  phase_t phase;
  phase_t phase_next;
  logic   take_item;

  assign s_tready  = !m_tvalid || m_tready;
  assign take_item = s_tvalid && s_tready;

  always_comb begin
    cmd           = '0;
    cmd.item      = take_item && !s_tlast;
    cmd.emit      = take_item && s_tlast;
    cmd.base_sel  = SEL_ACTIVE;
    phase_next    = phase;
    case (phase)
      PH_ZERO:   cmd.fin_sel = FIN_ZERO;
      PH_DIGITS: cmd.fin_sel = FIN_DIGITS;
      PH_DONE:   cmd.fin_sel = FIN_DONE;
      default:   cmd.fin_sel = FIN_NONE;
    endcase

    if (cmd.emit) begin
      phase_next = PH_SPACE;
    end else if (cmd.item) begin
      case (phase)
        PH_SPACE, PH_FIRST: begin
          if (phase == PH_SPACE && stat.ch_space) begin
            phase_next = PH_SPACE;
          end else if (phase == PH_SPACE && stat.ch_minus) begin
            cmd.set_neg = 1'b1;
            phase_next  = PH_FIRST;
          end else if (phase == PH_SPACE && stat.ch_plus) begin
            phase_next = PH_FIRST;
          end else if (stat.ch_zero && (stat.raw_zero || stat.raw_hex || stat.raw_bin)) begin
            // a zero that may open a prefix: hold the raw base for the next item
            cmd.base_sel  = SEL_RAW;
            cmd.load_base = 1'b1;
            phase_next    = PH_ZERO;
          end else begin
            cmd.base_sel  = SEL_FIRST;
            cmd.load_base = 1'b1;
            cmd.take      = 1'b1;
            phase_next    = stat.digit_ok ? PH_DIGITS : PH_DONE;
          end
        end
        PH_ZERO: begin
          if (stat.ch_x && (stat.act_zero || stat.act_hex)) begin
            cmd.base_sel  = SEL_HEX;
            cmd.load_base = 1'b1;
            phase_next    = PH_PREFIX;
          end else if (stat.ch_b && (stat.act_zero || stat.act_bin)) begin
            cmd.base_sel  = SEL_BIN;
            cmd.load_base = 1'b1;
            phase_next    = PH_PREFIX;
          end else begin
            // the held zero is a digit, then this character is tried too
            cmd.base_sel  = SEL_ZERO;
            cmd.load_base = 1'b1;
            cmd.lead_zero = 1'b1;
            cmd.take      = 1'b1;
            phase_next    = stat.digit_ok ? PH_DIGITS : PH_DONE;
          end
        end
        PH_PREFIX, PH_DIGITS: begin
          cmd.take   = 1'b1;
          phase_next = stat.digit_ok ? PH_DIGITS : PH_DONE;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SPACE;
      m_tvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty result register");

  a_term_rearms: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (phase == PH_SPACE) && m_tvalid)
    else $error("terminator did not rearm the parser and present a result");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) && !cmd.emit |=> phase == PH_DONE)
    else $error("parser left the stopped phase before the terminator");

endmodule
